[hw/rtl/pli_pkg.sv]
`timescale 1ns / 1ps
// Shared widths, FSM codes and the request/response bundles of the serial multiply-divide unit.
// No dependencies; pli_muldiv and the top module of the interpolator import this package.
package pli_pkg;

    localparam int FREQ_W = 40;            // breakpoint / query frequency, unsigned
    localparam int VAL_W  = 32;            // breakpoint / result value, signed Q16.16
    localparam int MAG_W  = VAL_W + 1;     // magnitude of y2 - y1
    localparam int PROD_W = MAG_W + FREQ_W; // full width of mag * (f - x1)
    localparam int IDX_W  = 8;             // breakpoint index as seen on the stream
    localparam int PTS_W  = 9;             // points_used register
    localparam int CNT_W  = 7;             // step counter of the serial unit

    // Command carried in s_tuser
    typedef enum logic [0:0] {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    // Status carried in m_tuser
    typedef enum logic [0:0] {
        STATUS_OK     = 1'b0,
        STATUS_NO_SEG = 1'b1
    } status_t;

    typedef struct packed {
        logic              start;
        logic [MAG_W-1:0]  mag;
        logic [FREQ_W-1:0] num;
        logic [FREQ_W-1:0] den;
    } md_req_t;

    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] quot;
    } md_rsp_t;

    typedef enum logic [2:0] {
        MD_IDLE = 3'b001,
        MD_MUL  = 3'b010,
        MD_DIV  = 3'b100
    } md_state_t;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_FIRST = 8'b0000_0010,
        ST_LAST  = 8'b0000_0100,
        ST_CLAMP = 8'b0000_1000,
        ST_SCAN  = 8'b0001_0000,
        ST_PREP  = 8'b0010_0000,
        ST_CALC  = 8'b0100_0000,
        ST_RES   = 8'b1000_0000
    } pli_state_t;

endpackage

[hw/rtl/pli_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module pli_ram #(
    parameter  int WIDTH = 72,
    parameter  int DEPTH = 256,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/pli_muldiv.sv]
`timescale 1ns / 1ps
// Bit-serial unit: floor(mag * num / den) by shift-add multiply then restoring divide.
// Depends on pli_pkg for widths and the request/response bundles.
module pli_muldiv (
    input  logic             clk,
    input  logic             rst_n,
    input  pli_pkg::md_req_t req,
    output pli_pkg::md_rsp_t rsp
);

    import pli_pkg::*;

    localparam int MUL_STEPS = FREQ_W;
    localparam int DIV_STEPS = PROD_W;

    md_state_t         state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [MAG_W-1:0]  mag_reg;
    logic [FREQ_W-1:0] den_reg;
    logic [FREQ_W-1:0] rem_reg, rem_next;
    logic              done_reg, done_next;

    logic [MAG_W:0]    mul_sum;
    logic [FREQ_W:0]   div_shl;
    logic [FREQ_W:0]   div_diff;
    logic              div_ge;

    // Multiply: add mag into the upper half when the low bit is set, shift right.
    assign mul_sum = {1'b0, prod_reg[PROD_W-1 -: MAG_W]}
                   + (prod_reg[0] ? {1'b0, mag_reg} : {(MAG_W+1){1'b0}});

    // Divide: bring in the next dividend bit, subtract when it fits.
    assign div_shl  = {rem_reg, prod_reg[PROD_W-1]};
    assign div_diff = div_shl - {1'b0, den_reg};
    assign div_ge   = (div_shl >= {1'b0, den_reg});

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            MD_IDLE:
            begin
                if (req.start)
                begin
                    prod_next  = {{MAG_W{1'b0}}, req.num};
                    cnt_next   = '0;
                    state_next = MD_MUL;
                end
            end
            MD_MUL:
            begin
                prod_next = {mul_sum, prod_reg[FREQ_W-1:1]};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MUL_STEPS - 1))
                begin
                    cnt_next   = '0;
                    rem_next   = '0;
                    state_next = MD_DIV;
                end
            end
            MD_DIV:
            begin
                prod_next = {prod_reg[PROD_W-2:0], div_ge};
                rem_next  = div_ge ? div_diff[FREQ_W-1:0] : div_shl[FREQ_W-1:0];
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    done_next  = 1'b1;
                    state_next = MD_IDLE;
                end
            end
            default:
            begin
                state_next = MD_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        if (state_reg == MD_IDLE && req.start)
        begin
            mag_reg <= req.mag;
            den_reg <= req.den;
        end
    end

    // Quotient is below 2^MAG_W because num never exceeds den.
    assign rsp.done = done_reg;
    assign rsp.quot = prod_reg[MAG_W-1:0];

endmodule

[hw/rtl/piecewise_linear_interpolator.sv]
`timescale 1ns / 1ps
// Piecewise linear interpolation over a breakpoint table held in one RAM.
// Depends on pli_pkg, pli_ram and pli_muldiv.
//
// Usage:
//   s_* carries one beat per command. s_tuser selects: 0 writes breakpoint
//   point_index with (point_freq, point_value), 1 queries at query_freq.
//   A write beat is taken only while the block is idle, where back-to-back
//   writes run at one per cycle; it produces no output beat.
//   A query reads entry 0 and the last entry in use, clamps if the query
//   lies outside them, otherwise scans segments one per cycle (RAM read
//   port bound), then, for a bracketing segment of nonzero width, runs
//   the bit-serial multiply and the restoring divide.
//   The result beat sits in an output register: the block takes the next
//   command while it waits, and a later query stalls in its last step until
//   m_tready frees that register.
//   cfg_* writes points_used (always ready); write it only while idle.
//   Reset clears the FSM, the output valid and sets points_used to 1. The
//   table is not cleared: load every entry in use before querying.
module piecewise_linear_interpolator #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // s_tdata, low bit up: point_index[7:0], point_freq[39:0],
    //                      point_value[31:0], query_freq[39:0]
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [119:0]              s_tdata,
    // s_tuser, low bit up: cmd
    input  logic [0:0]                s_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // m_tdata, low bit up: interp_value[31:0]
    output logic [31:0]               m_tdata,
    // m_tuser, low bit up: status
    output logic [0:0]                m_tuser,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [pli_pkg::PTS_W-1:0] cfg_data
);

    import pli_pkg::*;

    localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CAP   = (TABLE_DEPTH < 256) ? TABLE_DEPTH : 256;
    localparam int ENT_W = FREQ_W + VAL_W;

    // Stream field split
    logic [IDX_W-1:0]  in_index;
    logic [FREQ_W-1:0] in_pfreq;
    logic [VAL_W-1:0]  in_pvalue;
    logic [FREQ_W-1:0] in_qfreq;
    logic              in_cmd;

    assign in_index  = s_tdata[7:0];
    assign in_pfreq  = s_tdata[47:8];
    assign in_pvalue = s_tdata[79:48];
    assign in_qfreq  = s_tdata[119:80];
    assign in_cmd    = s_tuser[0];

    pli_state_t        state_reg, state_next;
    logic [PTS_W-1:0]  pts_reg;
    logic [IDX_W-1:0]  cur_idx_reg;
    logic [FREQ_W-1:0] qf_reg;
    logic [FREQ_W-1:0] prev_x_reg;
    logic [VAL_W-1:0]  prev_y_reg;
    logic [FREQ_W-1:0] cur_x_reg;
    logic [VAL_W-1:0]  cur_y_reg;
    logic [VAL_W-1:0]  y1_reg;
    logic              interp_reg;
    logic              neg_reg;
    logic              fail_reg;
    logic              out_valid_reg;
    logic [VAL_W-1:0]  out_value_reg;
    logic              out_status_reg;

    logic              in_fire;
    logic              out_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;

    // Points in use: zero acts as one, clip at the table size.
    logic [PTS_W-1:0] pts_eff;
    logic [IDX_W-1:0] last_idx;

    always_comb
    begin
        pts_eff = pts_reg;
        if (pts_reg == '0)
        begin
            pts_eff = PTS_W'(1);
        end
        else if (pts_reg > PTS_W'(CAP))
        begin
            pts_eff = PTS_W'(CAP);
        end
    end

    assign last_idx = IDX_W'(pts_eff - PTS_W'(1));

    // Table RAM: {freq, value} per entry
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    logic [ENT_W-1:0]  ram_rdata;
    logic [FREQ_W-1:0] rd_x;
    logic [VAL_W-1:0]  rd_y;
    logic [IDX_W-1:0]  rd_idx;
    logic [AW+IDX_W-1:0] waddr_ext;
    logic [AW+IDX_W-1:0] raddr_ext;

    // Drop writes beyond the table.
    assign ram_we    = in_fire && (in_cmd == CMD_WRITE)
                    && (32'(in_index) < 32'(TABLE_DEPTH));
    assign waddr_ext = {{AW{1'b0}}, in_index};
    assign ram_waddr = waddr_ext[AW-1:0];

    always_comb
    begin
        rd_idx = cur_idx_reg + 1'b1;
        if (state_reg == ST_FIRST)
        begin
            rd_idx = '0;
        end
        else if (state_reg == ST_LAST)
        begin
            rd_idx = last_idx;
        end
    end

    assign raddr_ext = {{AW{1'b0}}, rd_idx};
    assign ram_raddr = raddr_ext[AW-1:0];
    assign rd_x      = ram_rdata[ENT_W-1:VAL_W];
    assign rd_y      = ram_rdata[VAL_W-1:0];

    pli_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({in_pfreq, in_pvalue}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Segment setup for the serial unit
    logic signed [MAG_W-1:0] dy;
    logic        [MAG_W-1:0] dy_mag;
    logic                    seg_zero;
    md_req_t                 md_req;
    md_rsp_t                 md_rsp;

    assign dy       = MAG_W'(signed'(cur_y_reg)) - MAG_W'(signed'(prev_y_reg));
    assign dy_mag   = dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
    assign seg_zero = (cur_x_reg == prev_x_reg);

    // Start the serial unit only for a real segment of nonzero width.
    assign md_req.start = (state_reg == ST_PREP) && !seg_zero && !fail_reg;
    assign md_req.mag   = dy_mag;
    assign md_req.num   = qf_reg - prev_x_reg;
    assign md_req.den   = cur_x_reg - prev_x_reg;

    pli_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .rsp   (md_rsp)
    );

    // Final value: y1 +/- q, saturated to the 32-bit range
    logic signed [VAL_W+2:0] res_sum;
    logic        [VAL_W-1:0] res_sat;

    always_comb
    begin
        res_sum = (VAL_W+3)'(signed'(y1_reg));
        if (interp_reg)
        begin
            if (neg_reg)
            begin
                res_sum = res_sum - (VAL_W+3)'(md_rsp.quot);
            end
            else
            begin
                res_sum = res_sum + (VAL_W+3)'(md_rsp.quot);
            end
        end
        if (res_sum > (VAL_W+3)'(signed'({1'b0, {(VAL_W-1){1'b1}}})))
        begin
            res_sat = {1'b0, {(VAL_W-1){1'b1}}};
        end
        else if (res_sum < (VAL_W+3)'(signed'({1'b1, {(VAL_W-1){1'b0}}})))
        begin
            res_sat = {1'b1, {(VAL_W-1){1'b0}}};
        end
        else
        begin
            res_sat = res_sum[VAL_W-1:0];
        end
        if (fail_reg)
        begin
            res_sat = '0;
        end
    end

    // Control sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (in_cmd == CMD_QUERY))
                begin
                    state_next = ST_FIRST;
                end
            end
            ST_FIRST:
            begin
                state_next = ST_LAST;
            end
            ST_LAST:
            begin
                state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                if (qf_reg <= prev_x_reg || qf_reg >= rd_x)
                begin
                    state_next = ST_RES;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if ((qf_reg >= prev_x_reg && qf_reg <= rd_x) || cur_idx_reg == last_idx)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                if (fail_reg || seg_zero)
                begin
                    state_next = ST_RES;
                end
                else
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (md_rsp.done)
                begin
                    state_next = ST_RES;
                end
            end
            ST_RES:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pts_reg       <= PTS_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                pts_reg <= cfg_data;
            end
            if (state_reg == ST_RES && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (in_cmd == CMD_QUERY))
                begin
                    qf_reg      <= in_qfreq;
                    cur_idx_reg <= '0;
                    fail_reg    <= 1'b0;
                    interp_reg  <= 1'b0;
                end
            end
            ST_FIRST:
            begin
            end
            ST_LAST:
            begin
                // Hold entry 0 as the left end of the first segment.
                prev_x_reg <= rd_x;
                prev_y_reg <= rd_y;
            end
            ST_CLAMP:
            begin
                if (qf_reg <= prev_x_reg)
                begin
                    y1_reg <= prev_y_reg;
                end
                else if (qf_reg >= rd_x)
                begin
                    y1_reg <= rd_y;
                end
                else
                begin
                    cur_idx_reg <= cur_idx_reg + 1'b1;
                end
            end
            ST_SCAN:
            begin
                if (qf_reg >= prev_x_reg && qf_reg <= rd_x)
                begin
                    cur_x_reg <= rd_x;
                    cur_y_reg <= rd_y;
                end
                else if (cur_idx_reg == last_idx)
                begin
                    // Unsorted table: no bracketing segment.
                    fail_reg <= 1'b1;
                end
                else
                begin
                    // Advance one segment.
                    prev_x_reg  <= rd_x;
                    prev_y_reg  <= rd_y;
                    cur_idx_reg <= cur_idx_reg + 1'b1;
                end
            end
            ST_PREP:
            begin
                y1_reg     <= prev_y_reg;
                neg_reg    <= dy[MAG_W-1];
                interp_reg <= !seg_zero && !fail_reg;
            end
            ST_CALC:
            begin
            end
            ST_RES:
            begin
                if (out_free)
                begin
                    out_value_reg  <= res_sat;
                    out_status_reg <= fail_reg ? STATUS_NO_SEG : STATUS_OK;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_value_reg;
    assign m_tuser[0] = out_status_reg;

endmodule
